// ===== hw/rtl/tag_group_table_with_id_pool_assert.svh =====
// Assertion macros for the tag group table
`ifndef TAG_GROUP_TABLE_WITH_ID_POOL_ASSERT_SVH
`define TAG_GROUP_TABLE_WITH_ID_POOL_ASSERT_SVH

// condition holds in the same cycle
`define TGTAB_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition holds in the following cycle
`define TGTAB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/tgtab_pkg.sv =====
package tgtab_pkg;

  localparam int MAX_GROUPS_DEF  = 8;
  localparam int MAX_MEMBERS_DEF = 8;
  localparam int NUM_IDS_DEF     = 16;
  localparam int NUM_SECTORS_DEF = 32;

  localparam int SEC_W = 5;
  localparam int TAG_W = 8;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_DROP    = 3'd1,
    CMD_BEGIN   = 3'd2,
    CMD_PRESENT = 3'd3,
    CMD_END     = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_READ    = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MEMBER      = 2'd1;
  localparam logic [1:0] ST_GROUP_FULL  = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL  = 2'd3;

  typedef struct packed {
    cmd_t             cmd;
    logic [SEC_W-1:0] sector_id;
    logic [TAG_W-1:0] tag;
    logic             in_active_set;
    logic [2:0]       group_index;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       valid_res;
    logic [4:0] group_id;
    logic [3:0] group_count;
    logic [3:0] group_size;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_TAG,
    S_GRP,
    S_MEM_RD,
    S_MEM_CMP,
    S_HIT,
    S_REM_WR,
    S_FREE_CHK,
    S_FREE_RD,
    S_FREE_WR,
    S_FREE_MV,
    S_END_HOLD,
    S_END_CMP,
    S_CLR,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/tgtab_ram.sv =====
module tgtab_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tag_group_table_with_id_pool.sv =====
// channel | signals                              | transaction
// cmd     | cmd_valid, cmd_ready, cmd_item (in_t)  | one command
// rsp     | rsp_valid, rsp_ready, rsp_item (out_t) | one result per command
// One command at a time; cmd_ready is high only while the sequencer is idle.
// Begin and no-op go straight to the result, and read looks up one group first;
// add, present and drop step through the groups and compare each member (one RAM
// read each), and drop also moves each member when a freed slot takes the last group.
// End update compares every pair of tags, one pair per cycle.
// Reset (rst, synchronous) refills the ID pool and empties the table at once.
// A waiting result holds in its register; the next command is still taken,
// and its own result stalls until the waiting one has gone.
`include "tag_group_table_with_id_pool_assert.svh"

module tag_group_table_with_id_pool #(
  parameter int MAX_GROUPS  = tgtab_pkg::MAX_GROUPS_DEF,
  parameter int MAX_MEMBERS = tgtab_pkg::MAX_MEMBERS_DEF,
  parameter int NUM_IDS     = tgtab_pkg::NUM_IDS_DEF,
  parameter int NUM_SECTORS = tgtab_pkg::NUM_SECTORS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  tgtab_pkg::in_t  cmd_item,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tgtab_pkg::out_t rsp_item
);

  localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GCW   = $clog2(MAX_GROUPS + 1);
  localparam int MCW   = $clog2(MAX_MEMBERS + 1);
  localparam int IW    = $clog2(NUM_IDS + 1);
  localparam int PW    = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int DEPTH = MAX_GROUPS * MAX_MEMBERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = tgtab_pkg::SEC_W;
  localparam int TW    = tgtab_pkg::TAG_W;

  tgtab_pkg::state_t state, state_next;
  tgtab_pkg::in_t    item;

  logic [TW-1:0]  tag_r   [MAX_GROUPS];
  logic [IW-1:0]  ident_r [MAX_GROUPS];
  logic           seen_r  [MAX_GROUPS];
  logic [MCW-1:0] cnt_r   [MAX_GROUPS];
  logic [IW-1:0]  pool    [NUM_IDS];
  logic [GCW-1:0] used;
  logic [PW-1:0]  take_idx, ret_idx;
  logic           update_ok;

  logic [GCW-1:0] gi, ei, fi;
  logic [MCW-1:0] mi;
  logic [TW-1:0]  hold;
  logic           hit;
  logic [1:0]     r_status;
  logic           r_valid;
  logic [4:0]     r_gid;
  logic [3:0]     r_size;

  logic [GW-1:0]  rsel;
  logic [TW-1:0]  tag_s;
  logic [IW-1:0]  ident_s;
  logic           seen_s;
  logic [MCW-1:0] cnt_s;
  logic [TW-1:0]  cmp_a, cmp_b;
  logic           eq;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [SW-1:0]  ram_wdata, ram_rdata;

  logic [GCW-1:0] last;
  logic [GCW-1:0] fim1;
  logic           sec_ok;
  logic           is_add, is_drop, removing, rsp_free;

  function automatic logic [AW-1:0] maddr(input logic [GCW-1:0] g, input logic [MCW-1:0] m);
    return AW'(g * MAX_MEMBERS + m);
  endfunction

  function automatic logic [PW-1:0] pnext(input logic [PW-1:0] p);
    return (p == PW'(NUM_IDS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign tag_s    = tag_r[rsel];
  assign ident_s  = ident_r[rsel];
  assign seen_s   = seen_r[rsel];
  assign cnt_s    = cnt_r[rsel];
  assign eq       = (cmp_a == cmp_b);
  assign last     = used - 1'b1;
  assign fim1     = fi - 1'b1;
  assign sec_ok   = (32'(cmd_item.sector_id) < NUM_SECTORS);
  assign is_add   = (item.cmd == tgtab_pkg::CMD_ADD);
  assign is_drop  = (item.cmd == tgtab_pkg::CMD_DROP);
  assign removing = is_drop || !item.in_active_set;
  assign rsp_free = !rsp_valid || rsp_ready;

  tgtab_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_members (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      tgtab_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd_item.cmd)
            tgtab_pkg::CMD_ADD:     state_next = sec_ok ? tgtab_pkg::S_ADD_TAG : tgtab_pkg::S_DONE;
            tgtab_pkg::CMD_DROP,
            tgtab_pkg::CMD_PRESENT: state_next = sec_ok ? tgtab_pkg::S_GRP : tgtab_pkg::S_DONE;
            tgtab_pkg::CMD_END:     state_next = tgtab_pkg::S_END_HOLD;
            tgtab_pkg::CMD_CLEAR:   state_next = tgtab_pkg::S_CLR;
            tgtab_pkg::CMD_READ:    state_next = tgtab_pkg::S_READ;
            default:                state_next = tgtab_pkg::S_DONE;
          endcase
        end
      end
      tgtab_pkg::S_ADD_TAG: begin
        if (gi == used) state_next = tgtab_pkg::S_DONE;
        else if (eq) state_next = tgtab_pkg::S_MEM_RD;
      end
      tgtab_pkg::S_GRP: begin
        if (gi == used) state_next = is_drop ? tgtab_pkg::S_FREE_CHK : tgtab_pkg::S_DONE;
        else state_next = tgtab_pkg::S_MEM_RD;
      end
      tgtab_pkg::S_MEM_RD: begin
        if (mi != cnt_s) state_next = tgtab_pkg::S_MEM_CMP;
        else if (is_add) state_next = tgtab_pkg::S_DONE;
        else state_next = tgtab_pkg::S_GRP;
      end
      tgtab_pkg::S_MEM_CMP: begin
        if (!eq) state_next = tgtab_pkg::S_MEM_RD;
        else if (is_add) state_next = tgtab_pkg::S_DONE;
        else state_next = tgtab_pkg::S_HIT;
      end
      tgtab_pkg::S_HIT:      state_next = removing ? tgtab_pkg::S_REM_WR : tgtab_pkg::S_GRP;
      tgtab_pkg::S_REM_WR:   state_next = tgtab_pkg::S_GRP;
      tgtab_pkg::S_FREE_CHK: begin
        if (fi == '0) state_next = tgtab_pkg::S_DONE;
        else if (cnt_s == '0) state_next = tgtab_pkg::S_FREE_RD;
      end
      tgtab_pkg::S_FREE_RD:  state_next = (mi != cnt_s) ? tgtab_pkg::S_FREE_WR : tgtab_pkg::S_FREE_MV;
      tgtab_pkg::S_FREE_WR:  state_next = tgtab_pkg::S_FREE_RD;
      tgtab_pkg::S_FREE_MV:  state_next = tgtab_pkg::S_FREE_CHK;
      tgtab_pkg::S_END_HOLD: state_next = (gi == used) ? tgtab_pkg::S_DONE : tgtab_pkg::S_END_CMP;
      tgtab_pkg::S_END_CMP:  if (ei == used) state_next = tgtab_pkg::S_END_HOLD;
      tgtab_pkg::S_CLR:      if (gi == used) state_next = tgtab_pkg::S_DONE;
      tgtab_pkg::S_READ:     state_next = tgtab_pkg::S_DONE;
      tgtab_pkg::S_DONE:     if (rsp_free) state_next = tgtab_pkg::S_IDLE;
      default:               state_next = tgtab_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    rsel      = gi[GW-1:0];
    cmp_a     = tag_s;
    cmp_b     = item.tag;
    ram_we    = 1'b0;
    ram_waddr = maddr(gi, mi);
    ram_wdata = item.sector_id;
    ram_raddr = maddr(gi, mi);
    case (state)
      tgtab_pkg::S_IDLE: cmd_ready = 1'b1;
      tgtab_pkg::S_ADD_TAG: begin
        if (gi == used && 32'(used) < MAX_GROUPS) begin
          ram_we    = 1'b1;
          ram_waddr = maddr(used, '0);
        end
      end
      tgtab_pkg::S_MEM_RD: begin
        if (mi == cnt_s && is_add && 32'(cnt_s) < MAX_MEMBERS) begin
          ram_we    = 1'b1;
          ram_waddr = maddr(gi, cnt_s);
        end
      end
      tgtab_pkg::S_MEM_CMP: begin
        cmp_a = TW'(ram_rdata);
        cmp_b = TW'(item.sector_id);
      end
      tgtab_pkg::S_HIT: ram_raddr = maddr(gi, cnt_s - 1'b1);
      tgtab_pkg::S_REM_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      tgtab_pkg::S_FREE_CHK: rsel = fim1[GW-1:0];
      tgtab_pkg::S_FREE_RD: begin
        rsel      = last[GW-1:0];
        ram_raddr = maddr(last, mi);
      end
      tgtab_pkg::S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = maddr(fi, mi);
        ram_wdata = ram_rdata;
      end
      tgtab_pkg::S_FREE_MV: rsel = last[GW-1:0];
      tgtab_pkg::S_END_CMP: begin
        rsel  = ei[GW-1:0];
        cmp_a = hold;
        cmp_b = tag_s;
      end
      tgtab_pkg::S_READ: rsel = GW'(item.group_index);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tgtab_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      take_idx  <= '0;
      ret_idx   <= '0;
      update_ok <= 1'b1;
      rsp_valid <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        seen_r[i] <= 1'b0;
        cnt_r[i]  <= '0;
      end
      for (int i = 0; i < NUM_IDS; i++) pool[i] <= IW'(i + 1);
    end else begin
      if (rsp_valid && rsp_ready && state != tgtab_pkg::S_DONE) rsp_valid <= 1'b0;
      case (state)
        tgtab_pkg::S_IDLE: begin
          if (cmd_valid) begin
            item     <= cmd_item;
            gi       <= '0;
            mi       <= '0;
            hit      <= 1'b0;
            r_status <= tgtab_pkg::ST_OK;
            r_valid  <= 1'b0;
            r_gid    <= '0;
            r_size   <= '0;
            if (cmd_item.cmd == tgtab_pkg::CMD_BEGIN) begin
              update_ok <= 1'b1;
              for (int i = 0; i < MAX_GROUPS; i++) seen_r[i] <= 1'b0;
            end
          end
        end
        tgtab_pkg::S_ADD_TAG: begin
          if (gi == used) begin
            if (32'(used) >= MAX_GROUPS) begin
              r_status <= tgtab_pkg::ST_TABLE_FULL;
            end else begin
              tag_r[used[GW-1:0]]   <= item.tag;
              ident_r[used[GW-1:0]] <= pool[take_idx];
              seen_r[used[GW-1:0]]  <= 1'b0;
              cnt_r[used[GW-1:0]]   <= MCW'(1);
              used                  <= used + 1'b1;
              take_idx              <= pnext(take_idx);
              r_gid                 <= 5'(pool[take_idx]);
              r_size                <= 4'd1;
            end
          end else if (eq) begin
            r_gid <= 5'(ident_s);
            mi    <= '0;
          end else begin
            gi <= gi + 1'b1;
          end
        end
        tgtab_pkg::S_GRP: mi <= '0;
        tgtab_pkg::S_MEM_RD: begin
          if (mi == cnt_s) begin
            if (is_add) begin
              if (32'(cnt_s) >= MAX_MEMBERS) begin
                r_status <= tgtab_pkg::ST_GROUP_FULL;
                r_size   <= 4'(cnt_s);
              end else begin
                cnt_r[rsel] <= cnt_s + 1'b1;
                r_size      <= 4'(cnt_s + 1'b1);
              end
            end else begin
              gi <= gi + 1'b1;
            end
          end
        end
        tgtab_pkg::S_MEM_CMP: begin
          if (!eq) mi <= mi + 1'b1;
          else if (is_add) begin
            r_status <= tgtab_pkg::ST_MEMBER;
            r_size   <= 4'(cnt_r[gi[GW-1:0]]);
          end
        end
        tgtab_pkg::S_HIT: begin
          if (!removing) begin
            if (!seen_s) begin
              tag_r[rsel]  <= item.tag;
              seen_r[rsel] <= 1'b1;
            end else if (!eq) begin
              update_ok <= 1'b0;
            end
            if (!hit) begin
              hit    <= 1'b1;
              r_size <= 4'(cnt_s);
              r_gid  <= 5'(ident_s);
            end
            gi <= gi + 1'b1;
          end
        end
        tgtab_pkg::S_REM_WR: begin
          cnt_r[rsel] <= cnt_s - 1'b1;
          if (!hit) begin
            hit    <= 1'b1;
            r_size <= 4'(cnt_s - 1'b1);
            if (!is_drop) r_gid <= 5'(ident_s);
          end
          gi <= gi + 1'b1;
          if (state_next == tgtab_pkg::S_GRP && is_drop) fi <= used;
        end
        tgtab_pkg::S_FREE_CHK: begin
          if (fi != '0) begin
            fi <= fim1;
            mi <= '0;
            if (cnt_s == '0) begin
              pool[ret_idx] <= ident_s;
              ret_idx       <= pnext(ret_idx);
            end
          end
        end
        tgtab_pkg::S_FREE_WR: mi <= mi + 1'b1;
        tgtab_pkg::S_FREE_MV: begin
          if (fi != last) begin
            tag_r[fi[GW-1:0]]   <= tag_s;
            ident_r[fi[GW-1:0]] <= ident_s;
            seen_r[fi[GW-1:0]]  <= seen_s;
            cnt_r[fi[GW-1:0]]   <= cnt_s;
          end
          cnt_r[rsel]  <= '0;
          seen_r[rsel] <= 1'b0;
          used         <= last;
        end
        tgtab_pkg::S_END_HOLD: begin
          if (gi == used) r_valid <= update_ok;
          else begin
            hold <= tag_s;
            ei   <= gi + 1'b1;
          end
        end
        tgtab_pkg::S_END_CMP: begin
          if (ei == used) gi <= gi + 1'b1;
          else begin
            if (eq) update_ok <= 1'b0;
            ei <= ei + 1'b1;
          end
        end
        tgtab_pkg::S_CLR: begin
          if (gi == used) begin
            used <= '0;
            for (int i = 0; i < MAX_GROUPS; i++) begin
              seen_r[i] <= 1'b0;
              cnt_r[i]  <= '0;
            end
          end else begin
            pool[ret_idx] <= ident_s;
            ret_idx       <= pnext(ret_idx);
            gi            <= gi + 1'b1;
          end
        end
        tgtab_pkg::S_READ: begin
          if (32'(item.group_index) < 32'(used) && 32'(item.group_index) < MAX_GROUPS) begin
            r_gid  <= 5'(ident_s);
            r_size <= 4'(cnt_s);
          end
        end
        tgtab_pkg::S_DONE: begin
          if (rsp_free) begin
            rsp_valid            <= 1'b1;
            rsp_item.status      <= r_status;
            rsp_item.valid_res   <= r_valid;
            rsp_item.group_id    <= r_gid;
            rsp_item.group_count <= 4'(used);
            rsp_item.group_size  <= r_size;
          end
        end
        default: ;
      endcase
      if (state == tgtab_pkg::S_GRP && gi == used) fi <= used;
    end
  end

  `TGTAB_ASSERT_NOW(a_used_bound, 1'b1, 32'(used) <= MAX_GROUPS, "group count beyond table size")
  `TGTAB_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")
  `TGTAB_ASSERT_NOW(a_pool_idx, 1'b1, 32'(take_idx) < NUM_IDS && 32'(ret_idx) < NUM_IDS, "pool index out of range")

endmodule

// ===== sim/tag_group_table_with_id_pool_test.sv =====
module tag_group_table_with_id_pool_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NG = 8;
  localparam int NM = 8;
  localparam int NI = 16;

  class group_table_board;
    logic [7:0] tag_of [NG];
    logic [4:0] ident [NG];
    bit seen [NG];
    int count [NG];
    logic [4:0] members [NG][NM];
    int in_use;
    logic [4:0] pool [NI];
    int take_ix, give_ix;
    bit pass_ok;
    tgtab_pkg::out_t pending [$];
    int mismatches;

    function void clear_state();
      for (int i = 0; i < NG; i++) begin
        tag_of[i] = 0; ident[i] = 0; seen[i] = 0; count[i] = 0;
        for (int j = 0; j < NM; j++) members[i][j] = 0;
      end
      for (int i = 0; i < NI; i++) pool[i] = 5'(i + 1);
      in_use = 0; take_ix = 0; give_ix = 0; pass_ok = 1; mismatches = 0;
    endfunction

    function void give_id(logic [4:0] id);
      pool[give_ix] = id;
      give_ix = (give_ix + 1) % NI;
    endfunction

    function int find_member(int g, logic [4:0] s);
      for (int m = 0; m < count[g]; m++)
        if (members[g][m] == s) return m;
      return -1;
    endfunction

    function void note_command(tgtab_pkg::in_t c);
      tgtab_pkg::out_t r;
      int g, m, hit, last;
      r = '0;
      hit = -1;
      case (c.cmd)
        tgtab_pkg::CMD_ADD: begin
          for (g = 0; g < in_use; g++) if (tag_of[g] == c.tag) break;
          if (g < in_use) begin
            r.group_id = ident[g];
            if (find_member(g, c.sector_id) >= 0) r.status = tgtab_pkg::ST_MEMBER;
            else if (count[g] >= NM) r.status = tgtab_pkg::ST_GROUP_FULL;
            else begin
              members[g][count[g]] = c.sector_id;
              count[g]++;
            end
            r.group_size = 4'(count[g]);
          end else if (in_use >= NG) begin
            r.status = tgtab_pkg::ST_TABLE_FULL;
          end else begin
            g = in_use++;
            tag_of[g] = c.tag;
            ident[g] = pool[take_ix];
            take_ix = (take_ix + 1) % NI;
            seen[g] = 0;
            members[g][0] = c.sector_id;
            count[g] = 1;
            r.group_id = ident[g];
            r.group_size = 1;
          end
        end
        tgtab_pkg::CMD_DROP, tgtab_pkg::CMD_PRESENT: begin
          for (g = 0; g < in_use; g++) begin
            m = find_member(g, c.sector_id);
            if (m < 0) continue;
            if (c.cmd == tgtab_pkg::CMD_DROP || !c.in_active_set) begin
              members[g][m] = members[g][count[g] - 1];
              count[g]--;
            end else if (!seen[g]) begin
              tag_of[g] = c.tag;
              seen[g] = 1;
            end else if (tag_of[g] != c.tag) pass_ok = 0;
            if (hit < 0) begin
              hit = g;
              r.group_size = 4'(count[g]);
              if (c.cmd == tgtab_pkg::CMD_PRESENT) r.group_id = ident[g];
            end
          end
          if (c.cmd == tgtab_pkg::CMD_DROP) begin
            for (int i = in_use - 1; i >= 0; i--) begin
              if (count[i] != 0) continue;
              give_id(ident[i]);
              last = in_use - 1;
              tag_of[i] = tag_of[last];
              ident[i] = ident[last];
              seen[i] = seen[last];
              count[i] = count[last];
              members[i] = members[last];
              count[last] = 0;
              seen[last] = 0;
              in_use = last;
            end
          end
        end
        tgtab_pkg::CMD_BEGIN: begin
          for (int i = 0; i < NG; i++) seen[i] = 0;
          pass_ok = 1;
        end
        tgtab_pkg::CMD_END: begin
          for (int i = 0; i < in_use; i++)
            for (int j = i + 1; j < in_use; j++)
              if (tag_of[i] == tag_of[j]) pass_ok = 0;
          r.valid_res = pass_ok;
        end
        tgtab_pkg::CMD_CLEAR: begin
          for (int i = 0; i < in_use; i++) give_id(ident[i]);
          for (int i = 0; i < NG; i++) begin
            seen[i] = 0; count[i] = 0;
          end
          in_use = 0;
        end
        tgtab_pkg::CMD_READ: begin
          if (c.group_index < in_use) begin
            r.group_id = ident[c.group_index];
            r.group_size = 4'(count[c.group_index]);
          end
        end
        default: ;
      endcase
      r.group_count = 4'(in_use);
      pending.push_back(r);
    endfunction

    function void check_result(tgtab_pkg::out_t got);
      tgtab_pkg::out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.valid_res !== want.valid_res ||
          got.group_id !== want.group_id || got.group_count !== want.group_count ||
          got.group_size !== want.group_size) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected st=%0d v=%0d id=%0d cnt=%0d sz=%0d,",
                    " got st=%0d v=%0d id=%0d cnt=%0d sz=%0d"},
                   want.status, want.valid_res, want.group_id, want.group_count,
                   want.group_size, got.status, got.valid_res, got.group_id,
                   got.group_count, got.group_size);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cmd_valid = 0;
  logic cmd_ready;
  tgtab_pkg::in_t cmd_item = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  tgtab_pkg::out_t rsp_item;
  group_table_board board = new();

  always #6 clk = ~clk;

  tag_group_table_with_id_pool DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_item(cmd_item),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
  );

  task automatic send_command(tgtab_pkg::in_t c, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      cmd_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd_item <= c;
    cmd_valid <= 1;
    do @(posedge clk); while (!cmd_ready);
    board.note_command(c);
  endtask

  function automatic tgtab_pkg::in_t make_cmd(tgtab_pkg::cmd_t k, int sec, int tg,
                                              bit act = 1, int gi = 0);
    tgtab_pkg::in_t c;
    c.cmd = k;
    c.sector_id = 5'(sec);
    c.tag = 8'(tg);
    c.in_active_set = act;
    c.group_index = 3'(gi);
    return c;
  endfunction

  task automatic await_drain();
    cmd_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_pass(output int sent_here);
    int n;
    send_command(make_cmd(tgtab_pkg::CMD_BEGIN, $urandom_range(0, 31), $urandom_range(0, 255)));
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      send_command(make_cmd(tgtab_pkg::CMD_PRESENT, $urandom_range(0, 31),
                            $urandom_range(0, 11), $urandom_range(0, 4) != 0));
    send_command(make_cmd(tgtab_pkg::CMD_END, $urandom_range(0, 31), $urandom_range(0, 255)));
    sent_here = n + 2;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_result(rsp_item);
  end

  initial begin
    int stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        rsp_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin
    int sent;
    int r;
    int k;
    board.clear_state();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int s = 0; s < 9; s++)
      send_command(make_cmd(tgtab_pkg::CMD_ADD, s, s * 31 + 1));
    send_command(make_cmd(tgtab_pkg::CMD_ADD, 0, 1));
    for (int s = 10; s < 18; s++) send_command(make_cmd(tgtab_pkg::CMD_ADD, s, 32), 1);
    send_command(make_cmd(tgtab_pkg::CMD_ADD, 31, 32));
    send_command(make_cmd(tgtab_pkg::CMD_READ, 0, 0, 0, 7));
    send_command(make_cmd(tgtab_pkg::CMD_READ, 0, 0, 0, 1));
    send_command(make_cmd(tgtab_pkg::CMD_BEGIN, 0, 0));
    send_command(make_cmd(tgtab_pkg::CMD_PRESENT, 10, 255, 1));
    send_command(make_cmd(tgtab_pkg::CMD_PRESENT, 11, 0, 1));
    send_command(make_cmd(tgtab_pkg::CMD_PRESENT, 0, 0, 0));
    send_command(make_cmd(tgtab_pkg::CMD_END, 0, 0));
    send_command(make_cmd(tgtab_pkg::CMD_DROP, 1, 0));
    send_command(make_cmd(tgtab_pkg::CMD_NOP, 31, 255, 1, 7));
    send_command(make_cmd(tgtab_pkg::CMD_CLEAR, 0, 0));
    await_drain();

    sent = 0;
    while (sent < 400) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_command(make_cmd(tgtab_pkg::CMD_ADD, $urandom_range(0, 31), $urandom_range(0, 11)));
        sent++;
      end else if (r < 55) begin
        send_command(make_cmd(tgtab_pkg::CMD_DROP, $urandom_range(0, 31),
                              $urandom_range(0, 255)));
        sent++;
      end else if (r < 70) begin
        random_pass(k);
        sent += k;
      end else if (r < 82) begin
        send_command(make_cmd(tgtab_pkg::CMD_READ, $urandom_range(0, 31), $urandom_range(0, 255),
                              $urandom_range(0, 1), $urandom_range(0, 7)));
        sent++;
      end else if (r < 85) begin
        send_command(make_cmd(tgtab_pkg::CMD_CLEAR, 0, 0));
        sent++;
      end else begin
        send_command(make_cmd(tgtab_pkg::cmd_t'($urandom_range(0, 7)), $urandom_range(0, 31),
                              $urandom_range(0, 255), $urandom_range(0, 1),
                              $urandom_range(0, 7)));
        sent++;
      end
      if (sent % 100 == 0) await_drain();
    end
    await_drain();
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
